[src/qte_pkg.sv]
// Package for the quaternion to Euler angle converter: types, constants and helpers.
package qte_pkg;

	localparam int SampleWidth = 16;
	localparam int CordicSteps = 16;
	localparam int ScaleShift = 28 - (SampleWidth - 2);
	// CORDIC operand width: Q28 terms span about 34 bits before scaling.
	localparam int OpWidth = 36 - ScaleShift;
	localparam int AccWidth = 34;
	localparam int SqrtBits = 29;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} qte_in_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic               pitch_saturated;
	} qte_out_t;

	// Arctangent of 2^-i in binary angle units with 16 extra fraction bits.
	function automatic logic signed [AccWidth-1:0] atan_unit(input logic [4:0] idx);
		logic signed [AccWidth-1:0] v;
		case (idx)
			5'd0: v = 34'sd536870912;
			5'd1: v = 34'sd316933406;
			5'd2: v = 34'sd167458907;
			5'd3: v = 34'sd85004756;
			5'd4: v = 34'sd42667331;
			5'd5: v = 34'sd21354465;
			5'd6: v = 34'sd10679838;
			5'd7: v = 34'sd5340245;
			5'd8: v = 34'sd2670163;
			5'd9: v = 34'sd1335087;
			5'd10: v = 34'sd667544;
			5'd11: v = 34'sd333772;
			5'd12: v = 34'sd166886;
			5'd13: v = 34'sd83443;
			5'd14: v = 34'sd41722;
			5'd15: v = 34'sd20861;
			5'd16: v = 34'sd10430;
			5'd17: v = 34'sd5215;
			5'd18: v = 34'sd2608;
			5'd19: v = 34'sd1304;
			5'd20: v = 34'sd652;
			5'd21: v = 34'sd326;
			5'd22: v = 34'sd163;
			5'd23: v = 34'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[src/qte_cordic.sv]
// Pipelined CORDIC vectoring unit: atan2 of two operands, one stage per iteration.
module qte_cordic (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [qte_pkg::OpWidth-1:0] op_y,
	input  logic signed [qte_pkg::OpWidth-1:0] op_x,
	output logic signed [15:0]                angle
);
	import qte_pkg::*;

	localparam int Xw = OpWidth + 2;

	logic signed [Xw-1:0]       x_s [CordicSteps+1];
	logic signed [Xw-1:0]       y_s [CordicSteps+1];
	logic signed [AccWidth-1:0] a_s [CordicSteps+1];
	logic                       z_s [CordicSteps+1];

	logic signed [Xw-1:0] px, py;
	logic signed [AccWidth-1:0] pa;
	logic pz;
	logic signed [AccWidth-1:0] rnd;

	// Quarter-turn pre-rotation when x is negative.
	always_comb begin
		px = Xw'(op_x);
		py = Xw'(op_y);
		pa = '0;
		pz = (op_x == '0) && (op_y == '0);
		if (op_x < 0) begin
			if (op_y >= 0) begin
				px = Xw'(op_y); py = -Xw'(op_x); pa = 34'sd1073741824;
			end else begin
				px = -Xw'(op_y); py = Xw'(op_x); pa = -34'sd1073741824;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= px; y_s[0] <= py; a_s[0] <= pa; z_s[0] <= pz;
		end
	end

	// One micro-rotation per stage.
	for (genvar i = 0; i < CordicSteps; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i+1] <= z_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + atan_unit(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - atan_unit(5'(i));
				end
			end
		end
	end

	// Round half up to whole units; zero vector gives zero.
	assign rnd = a_s[CordicSteps] + 34'sd32768;
	assign angle = z_s[CordicSteps] ? 16'sd0 : rnd[31:16];
endmodule

[src/qte_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module qte_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [57:0]                   rad,
	output logic [qte_pkg::SqrtBits-1:0]  root
);
	import qte_pkg::*;

	logic [57:0]         r_s [SqrtBits+1];
	logic [SqrtBits-1:0] q_s [SqrtBits+1];

	always_comb begin
		r_s[0] = rad;
		q_s[0] = '0;
	end

	// Restoring square root: each stage resolves bit (SqrtBits-1-i).
	for (genvar i = 0; i < SqrtBits; i++) begin : g_bit
		localparam int B = SqrtBits - 1 - i;
		logic [57:0] trial;
		assign trial = ({29'd0, q_s[i]} << (B + 1)) + (58'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (r_s[i] >= trial) begin
					r_s[i+1] <= r_s[i] - trial;
					q_s[i+1] <= q_s[i] | (SqrtBits'(1) << B);
				end else begin
					r_s[i+1] <= r_s[i];
					q_s[i+1] <= q_s[i];
				end
			end
		end
	end

	assign root = q_s[SqrtBits];
endmodule

[src/quaternion_to_euler_angles_top.sv]
// Throughput: one quaternion per cycle; every stage advances when the output is free.
// The pipeline is a single shift chain: the sqrt stages and the CORDIC stages of all
// three angles move together, so roll and yaw are delayed to line up with pitch.
// Reset clears only the valid bits; data registers are not reset.
module quaternion_to_euler_angles_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qte_pkg::qte_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output qte_pkg::qte_out_t out_data
);
	import qte_pkg::*;

	localparam int Depth = 5 + SqrtBits + CordicSteps;

	logic [Depth-1:0] vld_q;
	logic en;

	// Whole pipe advances unless the final result is held.
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	// Stage 1: products.
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= in_data.quat_w * in_data.quat_x;
			yz_s1 <= in_data.quat_y * in_data.quat_z;
			xx_s1 <= in_data.quat_x * in_data.quat_x;
			yy_s1 <= in_data.quat_y * in_data.quat_y;
			wy_s1 <= in_data.quat_w * in_data.quat_y;
			zx_s1 <= in_data.quat_z * in_data.quat_x;
			wz_s1 <= in_data.quat_w * in_data.quat_z;
			xy_s1 <= in_data.quat_x * in_data.quat_y;
			zz_s1 <= in_data.quat_z * in_data.quat_z;
		end
	end

	// Stage 2: Q28 sums.
	logic signed [34:0] sr_s2, cr_s2, sp_s2, sy_s2, cy_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= 35'(wx_s1) + 35'(yz_s1) <<< 1;
			cr_s2 <= (35'sd1 <<< 28) - ((35'(xx_s1) + 35'(yy_s1)) <<< 1);
			sp_s2 <= (35'(wy_s1) - 35'(zx_s1)) <<< 1;
			sy_s2 <= (35'(wz_s1) + 35'(xy_s1)) <<< 1;
			cy_s2 <= (35'sd1 <<< 28) - ((35'(yy_s1) + 35'(zz_s1)) <<< 1);
		end
	end

	// Stage 3: saturation test and magnitude of sp.
	logic        hi_s3, lo_s3;
	logic [28:0] mag_s3;
	logic signed [34:0] sp_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s3 <= sp_s2 >= (35'sd1 <<< 28);
			lo_s3 <= sp_s2 <= -(35'sd1 <<< 28);
			mag_s3 <= sp_s2[34] ? 29'(-sp_s2) : 29'(sp_s2);
			sp_s3 <= sp_s2;
		end
	end

	// Stage 4: radicand 2^56 - sp^2 (sp held below 2^28 where used).
	logic [57:0] rad_s4;
	logic        hi_s4, lo_s4;
	logic signed [34:0] sp_s4;
	logic [57:0] sq;
	assign sq = 58'(mag_s3) * 58'(mag_s3);
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4 <= (hi_s3 || lo_s3) ? '0 : (58'd1 << 56) - sq;
			hi_s4 <= hi_s3;
			lo_s4 <= lo_s3;
			sp_s4 <= sp_s3;
		end
	end

	// Delay roll and yaw terms to line up with the square root.
	localparam int Dly = SqrtBits + 2;
	logic signed [34:0] sr_d [Dly], cr_d [Dly], sy_d [Dly], cy_d [Dly];
	logic signed [34:0] sp_d [SqrtBits];
	logic hi_d [SqrtBits], lo_d [SqrtBits];
	always_ff @(posedge clk) begin
		if (en) begin
			sr_d[0] <= sr_s2; cr_d[0] <= cr_s2; sy_d[0] <= sy_s2; cy_d[0] <= cy_s2;
			for (int k = 1; k < Dly; k++) begin
				sr_d[k] <= sr_d[k-1]; cr_d[k] <= cr_d[k-1];
				sy_d[k] <= sy_d[k-1]; cy_d[k] <= cy_d[k-1];
			end
			sp_d[0] <= sp_s4; hi_d[0] <= hi_s4; lo_d[0] <= lo_s4;
			for (int k = 1; k < SqrtBits; k++) begin
				sp_d[k] <= sp_d[k-1]; hi_d[k] <= hi_d[k-1]; lo_d[k] <= lo_d[k-1];
			end
		end
	end

	logic [SqrtBits-1:0] root;
	qte_isqrt u_sqrt (.clk(clk), .en(en), .rad(rad_s4), .root(root));

	// Scale Q28 terms to CORDIC operands with floor rounding.
	logic signed [OpWidth-1:0] ry, rx, yy_op, yx_op, py_op, px_op;
	logic signed [34:0] rt35;
	assign rt35 = 35'(root);
	assign ry = OpWidth'(sr_d[Dly-1] >>> ScaleShift);
	assign rx = OpWidth'(cr_d[Dly-1] >>> ScaleShift);
	assign yy_op = OpWidth'(sy_d[Dly-1] >>> ScaleShift);
	assign yx_op = OpWidth'(cy_d[Dly-1] >>> ScaleShift);
	assign py_op = OpWidth'(sp_d[SqrtBits-1] >>> ScaleShift);
	assign px_op = OpWidth'(rt35 >>> ScaleShift);

	logic signed [15:0] roll_a, yaw_a, pitch_a;
	qte_cordic u_roll  (.clk(clk), .en(en), .op_y(ry), .op_x(rx),
		.angle(roll_a));
	qte_cordic u_yaw   (.clk(clk), .en(en), .op_y(yy_op), .op_x(yx_op),
		.angle(yaw_a));
	qte_cordic u_pitch (.clk(clk), .en(en), .op_y(py_op), .op_x(px_op),
		.angle(pitch_a));

	// Saturation flags follow the CORDIC stages.
	logic hi_c [CordicSteps+1], lo_c [CordicSteps+1];
	always_ff @(posedge clk) begin
		if (en) begin
			hi_c[0] <= hi_d[SqrtBits-1]; lo_c[0] <= lo_d[SqrtBits-1];
			for (int k = 1; k <= CordicSteps; k++) begin
				hi_c[k] <= hi_c[k-1]; lo_c[k] <= lo_c[k-1];
			end
		end
	end

	// Pitch clamp and output assembly; angle outputs come from the last stage directly.
	logic hi_f, lo_f;
	assign hi_f = hi_c[CordicSteps];
	assign lo_f = lo_c[CordicSteps];
	always_comb begin
		out_data.roll_angle = roll_a;
		out_data.yaw_angle = yaw_a;
		out_data.pitch_saturated = hi_f || lo_f;
		if (hi_f) out_data.pitch_angle = 16'sd16384;
		else if (lo_f) out_data.pitch_angle = -16'sd16384;
		else if (pitch_a > 16'sd16384) out_data.pitch_angle = 16'sd16384;
		else if (pitch_a < -16'sd16384) out_data.pitch_angle = -16'sd16384;
		else out_data.pitch_angle = pitch_a;
	end
endmodule

[sim/quaternion_to_euler_angles_checker.sv]
// Checker for the quaternion to Euler angle converter: predicts each result and compares it.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  qte_pkg::qte_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  qte_pkg::qte_out_t out_data,
	output int                fail_count,
	output int                pending_count,
	output int                sat_count
);
	import qte_pkg::*;

	localparam int Shift = 28 - (SampleWidth - 2);
	localparam longint OneQ28 = 64'sd1 << 28;
	localparam longint QuarterTurn = 64'sd1 << 30;

	qte_out_t angle_queue[$];

	// Arithmetic shift right with floor rounding.
	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	// Floor integer square root, bit by bit.
	function automatic longint int_sqrt(input longint value);
		longint unsigned v, res, bt;
		v = value;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return longint'(res);
	endfunction

	// Vectoring-mode arctangent of Q28 terms, in whole angle units before wrapping.
	function automatic longint vector_angle(input longint yq, input longint xq);
		longint x, y, acc, t, dx, dy;
		x = floor_shift(xq, Shift);
		y = floor_shift(yq, Shift);
		acc = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; acc = QuarterTurn;
			end else begin
				x = -y; y = t; acc = -QuarterTurn;
			end
		end
		for (int i = 0; i < CordicSteps && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; acc += longint'(atan_unit(5'(i)));
			end else begin
				x -= dx; y += dy; acc -= longint'(atan_unit(5'(i)));
			end
		end
		return (acc + 32768) >>> 16;
	endfunction

	// Full roll, pitch and yaw prediction for one quaternion.
	function automatic qte_out_t predict_angles(input qte_in_t q);
		longint w, x, y, z, sr, cr, sp, sy, cy, pitch, mag;
		qte_out_t r;
		w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
		sr = 2 * (w * x + y * z);
		cr = OneQ28 - 2 * (x * x + y * y);
		sp = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = OneQ28 - 2 * (y * y + z * z);
		r.pitch_saturated = 1'b0;
		if (sp >= OneQ28) begin
			pitch = 16384; r.pitch_saturated = 1'b1;
		end else if (sp <= -OneQ28) begin
			pitch = -16384; r.pitch_saturated = 1'b1;
		end else begin
			mag = (sp < 0) ? -sp : sp;
			pitch = vector_angle(sp, int_sqrt((64'sd1 << 56) - mag * mag));
			if (pitch > 16384) pitch = 16384;
			if (pitch < -16384) pitch = -16384;
		end
		r.roll_angle = 16'(vector_angle(sr, cr));
		r.pitch_angle = 16'(pitch);
		r.yaw_angle = 16'(vector_angle(sy, cy));
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	assign pending_count = angle_queue.size();

	// Predict on each input transaction and compare each output transaction.
	always @(posedge clk or negedge arst_n) begin
		qte_out_t want;
		if (!arst_n) begin
			fail_count = 0;
			sat_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (angle_queue.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					want = angle_queue.pop_front();
					if (out_data.roll_angle !== want.roll_angle)
						report_mismatch("roll", out_data.roll_angle, want.roll_angle);
					if (out_data.pitch_angle !== want.pitch_angle)
						report_mismatch("pitch", out_data.pitch_angle, want.pitch_angle);
					if (out_data.yaw_angle !== want.yaw_angle)
						report_mismatch("yaw", out_data.yaw_angle, want.yaw_angle);
					if (out_data.pitch_saturated !== want.pitch_saturated)
						report_mismatch("saturation flag", out_data.pitch_saturated,
							want.pitch_saturated);
				end
			end
			if (in_valid && in_ready) begin
				want = predict_angles(in_data);
				if (want.pitch_saturated) sat_count <= sat_count + 1;
				angle_queue.push_back(want);
			end
		end
	end

endmodule

[sim/testbench.sv]
// Testbench top for the quaternion to Euler angle converter: stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
	import qte_pkg::*;

	localparam int RandomItems = 1350;
	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	qte_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	qte_out_t out_data;
	int fail_count, pending_count, sat_count;
	int cycle_count = 0;
	int sent_count = 0;

	always #5 clk = ~clk;

	quaternion_to_euler_angles_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	quaternion_to_euler_angles_checker angle_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count), .sat_count(sat_count)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Random stalls on the result side, with stall-free stretches.
	initial begin
		int g;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 3) == 0) begin
				g = gap_length();
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	// Offer one quaternion and hold it until it is accepted.
	task automatic send_quat(input logic [15:0] w, x, y, z);
		in_valid <= 1'b1;
		in_data <= '{quat_w: w, quat_x: x, quat_y: y, quat_z: z};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic idle_gap(input int g);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Random component near the unit sphere or anywhere in 16 bits.
	function automatic logic [15:0] pick_part(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 32768)) - 16384);
			default: return 16'($signed($urandom_range(0, 4096)) - 2048);
		endcase
	endfunction

	initial begin
		int mode;
		logic [15:0] a, b, c, d;
		logic signed [31:0] s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity, zero vector, axis turns, gimbal lock, pi wrap, extremes.
		send_quat(16384, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(11585, 0, 11585, 0);
		send_quat(11585, 0, -11585, 0);
		send_quat(11585, 11585, 11585, 11585);
		send_quat(8192, 8192, 8192, -8192);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, -16384, 0, 0);
		send_quat(0, 0, -16384, 0);
		send_quat(0, 0, 0, -16384);
		send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		send_quat(16384, 1, 0, 0);
		send_quat(16384, -1, 0, 0);
		send_quat(0, 0, 0, 1);
		idle_gap(1);

		// Hold off until every expected result has arrived.
		while (pending_count != 0) @(posedge clk);

		// Random: mostly unit-range quaternions, some near gimbal lock, some raw noise.
		for (int n = 0; n < RandomItems; n++) begin
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				a = pick_part(1); b = pick_part(1); c = pick_part(1); d = pick_part(1);
			end else if (mode < 8) begin
				s = $signed($urandom_range(0, 400)) - 200;
				a = 16'(11585 + s); c = 16'(11585 - s);
				b = pick_part(2); d = pick_part(2);
				if ($urandom_range(0, 1)) c = -c;
			end else begin
				a = pick_part(0); b = pick_part(0); c = pick_part(0); d = pick_part(0);
			end
			send_quat(a, b, c, d);
			idle_gap(gap_length());
			if (n == RandomItems / 2) begin
				in_valid <= 1'b0;
				while (pending_count != 0) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d quaternions: axis turns, pi wrap, zero vector, extremes and noise.",
			sent_count);
		$display("Pitch clamp hit %0d times; random stalls on both channels.", sat_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
